// ----- rtl/core/sha256_pkg.sv -----
package sha256_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned LEN_W   = 64;
  localparam int unsigned FILL_W  = 6;
  localparam int unsigned ROUND_W = 6;
  localparam int unsigned WADDR_W = 4;
  localparam int unsigned NUM_H   = 8;

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

  typedef logic [WORD_W-1:0] word_t;

  // Initial hash value for word i
  function automatic word_t init_hash(input logic [IDX_W-1:0] i);
    word_t v;
    case (i)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  // Round constant for round j
  function automatic word_t round_k(input logic [ROUND_W-1:0] j);
    word_t v;
    case (j)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;
      default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ----- rtl/core/sha256_message_digest_top.sv -----
// SHA-256 digest engine over a byte stream.
// Input channel (in_*): one transfer per message byte. in_tdata holds the byte,
// in_tuser says the byte is present, in_tlast closes the message. A transfer
// with in_tuser low and in_tlast high closes a message without a byte (empty
// message allowed); one with both low is ignored.
// Output channel (out_*): after a message closes, eight transfers carry h0..h7,
// out_tuser the word index, out_tlast set on h7.
// Throughput: bytes are taken one per cycle while a block fills. When the 64th
// byte of a block arrives, in_tready drops while the block is compressed: the
// block words and the message schedule share one 16-word memory with two
// registered read ports, and each round needs four schedule reads.
// Closing a message adds a pad write, the zero and length fill writes, one or
// two compressions, then the eight output words; in_tready returns in the cycle
// after the h7 transfer.
// A stalled receiver holds the current word on out_tdata; nothing is lost.
// Reset (rst_n low, synchronous) loads the initial hash, clears the length and
// the fill count, and leaves the block memory as it was.
module sha256_message_digest_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sha256_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                             in_tuser,   // [0] byte_present
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sha256_pkg::WORD_W-1:0]    out_tdata,  // [31:0] digest_word
  output logic [sha256_pkg::IDX_W-1:0]     out_tuser,  // [2:0] word_index
  output logic                             out_tlast
);
  import sha256_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PAD, S_ZFILL, S_CINIT, S_RD1, S_RD2, S_SCHED, S_RLAST, S_HADD, S_EMIT
  } state_t;

  state_t               state_r;
  logic [FILL_W-1:0]    fill_r;
  logic [LEN_W-1:0]     bitcnt_r;
  word_t                acc_r;
  logic [WADDR_W:0]     cnt_r;
  logic                 fin_r;
  logic                 two_r;
  logic                 pend_last_r;
  logic [ROUND_W-1:0]   rnd_r;
  word_t                x16_r, x15_r, w_r, k_r;
  word_t                hash_r [NUM_H];
  word_t                var_r  [NUM_H];
  logic [IDX_W-1:0]     oidx_r;
  word_t                odata_r;
  logic                 ovalid_r;

  // block / schedule memory
  word_t                mem [2**WADDR_W];
  word_t                rd0_r, rd1_r;
  logic [WADDR_W-1:0]   ra0, ra1, waddr;
  logic                 we;
  word_t                wdata;

  logic                 in_xfer, out_xfer;
  logic [1:0]           lane;
  word_t                acc_nxt, pad_word, w_nxt;
  logic                 rnd_do;
  word_t                t1, t2;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == IDX_W'(NUM_H - 1));
  assign out_xfer   = ovalid_r && out_tready;
  assign lane       = fill_r[1:0];

  // merge the incoming byte and build the pad word (big-endian lanes)
  always_comb begin
    acc_nxt  = acc_r;
    pad_word = '0;
    for (int l = 0; l < 4; l++) begin
      if (l[1:0] == lane) begin
        acc_nxt[WORD_W-1-BYTE_W*l -: BYTE_W]  = in_tdata;
        pad_word[WORD_W-1-BYTE_W*l -: BYTE_W] = PAD_BYTE;
      end else if (l[1:0] < lane) begin
        pad_word[WORD_W-1-BYTE_W*l -: BYTE_W] = acc_r[WORD_W-1-BYTE_W*l -: BYTE_W];
      end
    end
  end

  // schedule word: first sixteen come straight from the block
  assign w_nxt = (rnd_r[ROUND_W-1:WADDR_W] == '0) ? x16_r
                 : x16_r + sig0(x15_r) + rd0_r + sig1(rd1_r);

  // read address and write port selection
  always_comb begin
    ra0   = rnd_r[WADDR_W-1:0];
    ra1   = rnd_r[WADDR_W-1:0] + WADDR_W'(1);
    we    = 1'b0;
    waddr = cnt_r[WADDR_W-1:0];
    wdata = '0;
    case (state_r)
      S_RD2: begin
        ra0 = rnd_r[WADDR_W-1:0] + WADDR_W'(9);
        ra1 = rnd_r[WADDR_W-1:0] + WADDR_W'(14);
      end
      S_IDLE: begin
        we    = in_xfer && in_tuser && (lane == 2'd3);
        waddr = fill_r[FILL_W-1:2];
        wdata = acc_nxt;
      end
      S_PAD: begin
        we    = 1'b1;
        waddr = fill_r[FILL_W-1:2];
        wdata = pad_word;
      end
      S_ZFILL: begin
        we    = !cnt_r[WADDR_W];
        waddr = cnt_r[WADDR_W-1:0];
        if (!two_r && cnt_r[WADDR_W-1:0] == WADDR_W'(14)) begin
          wdata = bitcnt_r[LEN_W-1:WORD_W];
        end else if (!two_r && cnt_r[WADDR_W-1:0] == WADDR_W'(15)) begin
          wdata = bitcnt_r[WORD_W-1:0];
        end
      end
      S_SCHED: begin
        we    = (rnd_r[ROUND_W-1:WADDR_W] != '0);
        waddr = rnd_r[WADDR_W-1:0];
        wdata = w_nxt;
      end
      default: begin
      end
    endcase
  end

  // hold the memory; reads are registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  // one compression round on the registered schedule word
  assign rnd_do = ((state_r == S_RD1) && (rnd_r != '0)) || (state_r == S_RLAST);
  assign t1 = var_r[7] + bsig1(var_r[4]) + ((var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]))
              + k_r + w_r;
  assign t2 = bsig0(var_r[0])
              + ((var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]));

  // sequencer, working registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      bitcnt_r    <= '0;
      fin_r       <= 1'b0;
      two_r       <= 1'b0;
      pend_last_r <= 1'b0;
      ovalid_r    <= 1'b0;
      oidx_r      <= '0;
      rnd_r       <= '0;
      cnt_r       <= '0;
      for (int i = 0; i < NUM_H; i++) begin
        hash_r[i] <= init_hash(IDX_W'(i));
      end
    end else begin
      if (rnd_do) begin
        var_r[7] <= var_r[6];
        var_r[6] <= var_r[5];
        var_r[5] <= var_r[4];
        var_r[4] <= var_r[3] + t1;
        var_r[3] <= var_r[2];
        var_r[2] <= var_r[1];
        var_r[1] <= var_r[0];
        var_r[0] <= t1 + t2;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_tuser) begin
              acc_r    <= acc_nxt;
              fill_r   <= fill_r + FILL_W'(1);
              bitcnt_r <= bitcnt_r + LEN_W'(BYTE_W);
              if (fill_r == '1) begin
                pend_last_r <= in_tlast;
                state_r     <= S_CINIT;
              end else if (in_tlast) begin
                state_r <= S_PAD;
              end
            end else if (in_tlast) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fin_r   <= 1'b1;
          two_r   <= (fill_r[FILL_W-1:3] == '1);
          cnt_r   <= {1'b0, fill_r[FILL_W-1:2]} + (WADDR_W+1)'(1);
          state_r <= S_ZFILL;
        end
        S_ZFILL: begin
          if (cnt_r[WADDR_W]) begin
            state_r <= S_CINIT;
          end else begin
            cnt_r <= cnt_r + (WADDR_W+1)'(1);
          end
        end
        S_CINIT: begin
          for (int i = 0; i < NUM_H; i++) begin
            var_r[i] <= hash_r[i];
          end
          rnd_r   <= '0;
          state_r <= S_RD1;
        end
        S_RD1: begin
          state_r <= S_RD2;
        end
        S_RD2: begin
          x16_r   <= rd0_r;
          x15_r   <= rd1_r;
          state_r <= S_SCHED;
        end
        S_SCHED: begin
          w_r <= w_nxt;
          k_r <= round_k(rnd_r);
          if (rnd_r == '1) begin
            state_r <= S_RLAST;
          end else begin
            rnd_r   <= rnd_r + ROUND_W'(1);
            state_r <= S_RD1;
          end
        end
        S_RLAST: begin
          rnd_r   <= '0;
          state_r <= S_HADD;
        end
        S_HADD: begin
          for (int i = 0; i < NUM_H; i++) begin
            hash_r[i] <= hash_r[i] + var_r[i];
          end
          if (fin_r) begin
            if (two_r) begin
              two_r   <= 1'b0;
              cnt_r   <= '0;
              state_r <= S_ZFILL;
            end else begin
              oidx_r   <= '0;
              odata_r  <= hash_r[0] + var_r[0];
              ovalid_r <= 1'b1;
              state_r  <= S_EMIT;
            end
          end else if (pend_last_r) begin
            pend_last_r <= 1'b0;
            state_r     <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_xfer) begin
            if (oidx_r == IDX_W'(NUM_H - 1)) begin
              ovalid_r <= 1'b0;
              oidx_r   <= '0;
              fin_r    <= 1'b0;
              fill_r   <= '0;
              bitcnt_r <= '0;
              for (int i = 0; i < NUM_H; i++) begin
                hash_r[i] <= init_hash(IDX_W'(i));
              end
              state_r <= S_IDLE;
            end else begin
              oidx_r  <= oidx_r + IDX_W'(1);
              odata_r <= hash_r[oidx_r + IDX_W'(1)];
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while digest words are pending");

  a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD1 || state_r == S_RD2) |-> !we)
    else $error("memory written during schedule read");

  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser && fill_r == '1) |=> (state_r == S_CINIT))
    else $error("full block not sent to compression");

  a_msg_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast) |=> (in_tready && fill_r == '0 && bitcnt_r == '0))
    else $error("message state not cleared after digest");
`endif

endmodule
